[design/a85_pkg.sv]
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types, character codes, result kinds and base-85 weights for the
// ASCII85 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a85_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;
    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_count;

    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_FLUSH = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    localparam t_byte CH_FIRST = 8'h21;   // '!'
    localparam t_byte CH_LAST  = 8'h75;   // 'u'
    localparam t_byte CH_Z     = 8'h7a;   // 'z'
    localparam t_byte CH_TILDE = 8'h7e;   // '~'
    localparam t_byte CH_GT    = 8'h3e;   // '>'
    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_BS    = 8'h08;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_LF    = 8'h0a;
    localparam t_byte CH_FF    = 8'h0c;
    localparam t_byte CH_CR    = 8'h0d;
    localparam t_byte CH_SP    = 8'h20;
    localparam t_byte CH_DEL   = 8'h7f;

    localparam t_count GROUP_LAST = 3'd4;
    localparam t_count BEATS_GROUP = 3'd4;

    // weight of the digit at position idx, most significant first
    function automatic t_word pow85(input t_count idx);
        t_word w;
        case (idx)
            3'd0:    w = 32'd52200625;
            3'd1:    w = 32'd614125;
            3'd2:    w = 32'd7225;
            3'd3:    w = 32'd85;
            default: w = 32'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/a85_if.sv]
// ----------------------------------------------------------------------------
// a85_in_if / a85_out_if
// Valid/ready channels for encoded characters and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface a85_in_if;
    import a85_pkg::*;
    logic  valid;
    logic  ready;
    t_byte char_in;
    logic  end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface a85_out_if;
    import a85_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    t_kind kind;
    logic  last;

    modport source (output valid, output data_byte, output kind, output last, input ready);
    modport sink   (input valid, input data_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

[design/ascii85_decoder.sv]
// ----------------------------------------------------------------------------
// ascii85_decoder
// ASCII85 character stream decoder with group flush and sticky error.
// ----------------------------------------------------------------------------
// The first result beat is registered and is offered in the cycle after the character beat is taken.
// Throughput: one character per cycle unless the result side stalls; an item with
// n results holds the input until its last result beat is being taken.
// Reset: synchronous active low, clears group, flags and result beat count.
`default_nettype none

module ascii85_decoder
    import a85_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    a85_in_if.sink     i_char,
    a85_out_if.source  o_res
);

    t_word  r_group,  n_group;
    t_count r_digits, n_digits;
    logic   r_tilde,  n_tilde;
    logic   r_ended,  n_ended;
    logic   r_error,  n_error;

    t_word  r_word,   n_word;
    t_count r_cnt,    n_cnt;
    t_kind  r_kind,   n_kind;

    logic   in_fire;
    logic   out_fire;
    t_byte  c;
    t_byte  digit;
    t_word  sum;

    assign out_fire       = o_res.valid && o_res.ready;
    assign i_char.ready   = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_res.ready);
    assign in_fire        = i_char.valid && i_char.ready;

    assign o_res.valid     = (r_cnt != 3'd0);
    assign o_res.data_byte = r_word[31:24];
    assign o_res.kind      = r_kind;
    assign o_res.last      = (r_cnt == 3'd1);

    assign c     = i_char.char_in;
    assign digit = c - CH_FIRST;
    assign sum   = r_group + 32'({24'd0, digit} * pow85(r_digits));

    always_comb begin
        n_group  = r_group;
        n_digits = r_digits;
        n_tilde  = r_tilde;
        n_ended  = r_ended;
        n_error  = r_error;
        n_word   = 32'd0;
        n_cnt    = 3'd0;
        n_kind   = KIND_BYTE;
        if (i_char.end_of_input) begin
            if (r_error || r_tilde) begin
                n_cnt  = 3'd1;
                n_kind = KIND_ERROR;
            end else if (r_digits >= 3'd2) begin
                n_word = r_group + pow85(r_digits - 3'd1);
                n_cnt  = r_digits - 3'd1;
            end else begin
                n_cnt  = 3'd1;
                n_kind = KIND_FLUSH;
            end
            n_group  = 32'd0;
            n_digits = 3'd0;
            n_tilde  = 1'b0;
            n_ended  = 1'b0;
            n_error  = 1'b0;
        end else if (r_error) begin
            n_cnt  = 3'd1;
            n_kind = KIND_ERROR;
        end else if (r_ended) begin
            n_cnt = 3'd0;
        end else if (r_tilde) begin
            if (c == CH_GT) begin
                n_tilde = 1'b0;
                n_ended = 1'b1;
            end else begin
                n_cnt   = 3'd1;
                n_kind  = KIND_ERROR;
                n_error = 1'b1;
            end
        end else if (c inside {CH_NUL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP, CH_DEL}) begin
            n_cnt = 3'd0;
        end else if (c == CH_Z) begin
            if (r_digits != 3'd0) begin
                n_cnt   = 3'd1;
                n_kind  = KIND_ERROR;
                n_error = 1'b1;
            end else begin
                n_cnt = BEATS_GROUP;
            end
        end else if (c == CH_TILDE) begin
            n_tilde = 1'b1;
        end else if (c inside {[CH_FIRST:CH_LAST]}) begin
            if (r_digits == GROUP_LAST) begin
                n_word   = sum;
                n_cnt    = BEATS_GROUP;
                n_group  = 32'd0;
                n_digits = 3'd0;
            end else begin
                n_group  = sum;
                n_digits = r_digits + 3'd1;
            end
        end else begin
            n_cnt   = 3'd1;
            n_kind  = KIND_ERROR;
            n_error = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group  <= 32'd0;
            r_digits <= 3'd0;
            r_tilde  <= 1'b0;
            r_ended  <= 1'b0;
            r_error  <= 1'b0;
            r_cnt    <= 3'd0;
        end else if (in_fire) begin
            r_group  <= n_group;
            r_digits <= n_digits;
            r_tilde  <= n_tilde;
            r_ended  <= n_ended;
            r_error  <= n_error;
            r_cnt    <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // load the result word on a taken character and advance it one beat per handshake
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= n_word;
            r_kind <= n_kind;
        end else if (out_fire) begin
            r_word <= {r_word[23:0], 8'd0};
        end
    end

endmodule

`default_nettype wire

[design/a85_checker.sv]
// ----------------------------------------------------------------------------
// a85_checker
// Port-level checks of the ASCII85 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_checker
    import a85_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_ready,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire t_byte out_data,
    input wire t_kind out_kind,
    input wire logic  out_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data)
            && $stable(out_kind) && $stable(out_last))
        else $error("stalled result beat changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind != 2'd3)
        else $error("result kind out of range");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_BYTE |-> out_last && out_data == 8'd0)
        else $error("status beat not single or carries data");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken while a group is draining");

endmodule

bind ascii85_decoder a85_checker u_a85_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_char.valid),
    .in_ready  (i_char.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_data  (o_res.data_byte),
    .out_kind  (o_res.kind),
    .out_last  (o_res.last)
);

`default_nettype wire

[bench/ascii85_decoder_chk.sv]
// ----------------------------------------------------------------------------
// ascii85_decoder_chk
// Watches the character and result channels of the ASCII85 decoder. Every
// character beat taken by the block is decoded here into the result beats it
// should cause. Every result beat is compared against the oldest of them.
// Mismatches, unexpected beats and per-kind totals are handed to the top.
// ----------------------------------------------------------------------------

module ascii85_decoder_chk
    import a85_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    a85_in_if    i_char,
    a85_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_bytes,
    output int   o_flushes,
    output int   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_byte data_byte;
        t_kind kind;
        logic  last;
    } t_beat;

    localparam t_word DIGIT_WEIGHT [5] = '{32'd52200625, 32'd614125, 32'd7225, 32'd85, 32'd1};

    t_beat  expected_beats [$];
    t_word  acc_value;
    t_count acc_digits;
    logic   tilde_open;
    logic   stream_done;
    logic   error_latched;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_bytes      = 0;
        o_flushes    = 0;
        o_errors     = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void clear_decode();
        acc_value     = '0;
        acc_digits    = '0;
        tilde_open    = 1'b0;
        stream_done   = 1'b0;
        error_latched = 1'b0;
    endfunction

    function automatic void push_beat(input t_byte b, input t_kind k, input logic l);
        t_beat beat;
        beat.data_byte = b;
        beat.kind      = k;
        beat.last      = l;
        expected_beats.insert(expected_beats.size(), beat);
    endfunction

    function automatic void push_word(input t_word v, input int n);
        for (int i = 0; i < n; i++) begin
            push_beat(v[31 - 8 * i -: 8], KIND_BYTE, i == n - 1);
        end
    endfunction

    function automatic void flag_error();
        error_latched = 1'b1;
        push_beat('0, KIND_ERROR, 1'b1);
    endfunction

    function automatic void decode_char(input t_byte c, input logic eoi);
        t_word digit;
        digit = t_word'(c - CH_FIRST);
        if (eoi) begin
            if (error_latched || tilde_open) begin
                push_beat('0, KIND_ERROR, 1'b1);
            end else if (acc_digits >= 3'd2) begin
                push_word(acc_value + DIGIT_WEIGHT[acc_digits - 1], int'(acc_digits) - 1);
            end else begin
                push_beat('0, KIND_FLUSH, 1'b1);
            end
            clear_decode();
            return;
        end
        if (error_latched) begin
            push_beat('0, KIND_ERROR, 1'b1);
            return;
        end
        if (stream_done) return;
        if (tilde_open) begin
            if (c == CH_GT) begin
                tilde_open  = 1'b0;
                stream_done = 1'b1;
            end else begin
                flag_error();
            end
            return;
        end
        case (c)
            CH_NUL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP, CH_DEL: begin
            end
            CH_Z: begin
                if (acc_digits != 3'd0) flag_error();
                else push_word('0, 4);
            end
            CH_TILDE: begin
                tilde_open = 1'b1;
            end
            default: begin
                if (c < CH_FIRST || c > CH_LAST) begin
                    flag_error();
                end else begin
                    acc_value  = acc_value + digit * DIGIT_WEIGHT[acc_digits];
                    acc_digits = acc_digits + 3'd1;
                    if (acc_digits == 3'd5) begin
                        push_word(acc_value, 4);
                        acc_value  = '0;
                        acc_digits = '0;
                    end
                end
            end
        endcase
    endfunction

    task automatic check_beat(input t_byte b, input t_kind k, input logic l);
        t_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat byte=%02h kind=%0d last=%0b with none pending",
                                      b, k, l));
            return;
        end
        want = expected_beats.pop_front();
        if (b !== want.data_byte || k !== want.kind || l !== want.last) begin
            report_mismatch($sformatf("byte %02h/%02h kind %0d/%0d last %0b/%0b (got/exp)",
                                      b, want.data_byte, k, want.kind, l, want.last));
        end
        case (k)
            KIND_BYTE:  o_bytes++;
            KIND_FLUSH: o_flushes++;
            default:    o_errors++;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decode();
            expected_beats.delete();
        end else begin
            if (i_char.valid && i_char.ready) begin
                decode_char(i_char.char_in, i_char.end_of_input);
            end
            if (i_res.valid && i_res.ready) begin
                check_beat(i_res.data_byte, i_res.kind, i_res.last);
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

[bench/ascii85_decoder_tb.sv]
// ----------------------------------------------------------------------------
// ascii85_decoder_tb
// Drives the ASCII85 decoder with a directed set of corner cases followed by
// random streams: full groups, 'z' groups, skipped whitespace, partial-group
// flushes, end markers, broken markers and stray bytes. Both channels idle
// in random bursts and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module ascii85_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import a85_pkg::*;

    localparam int ITEM_TARGET = 430;
    localparam int HOLD_AT     = 150;
    localparam int QUIET_AT    = 370;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 20;

    localparam t_byte SKIP_SET [8] = '{CH_NUL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP, CH_DEL};

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   items_sent;
    int   streams_sent;
    int   cycle_count;
    logic quiet;
    logic hold_long;
    int   fail_count;
    int   pending;
    int   byte_count;
    int   flush_count;
    int   error_count;

    a85_in_if  char_bus ();
    a85_out_if res_bus ();

    ascii85_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus)
    );

    ascii85_decoder_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (char_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes      (byte_count),
        .o_flushes    (flush_count),
        .o_errors     (error_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats still pending", cycle_count, pending);
        $display("FAILURE");
        $finish;
    end

    // one character beat; entered and left at a falling edge
    task automatic send_char(input t_byte c, input logic eoi);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.char_in      <= c;
        char_bus.end_of_input <= eoi;
        do @(posedge i_clk); while (!char_bus.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_noisy(input t_byte c);
        if ($urandom_range(0, 24) == 0) send_char(t_byte'($urandom_range(0, 255)), 1'b0);
        else send_char(c, 1'b0);
    endtask

    task automatic send_digit();
        if ($urandom_range(0, 5) == 0) send_char(SKIP_SET[$urandom_range(0, 7)], 1'b0);
        send_noisy(t_byte'($urandom_range(CH_FIRST, CH_LAST)));
    endtask

    task automatic send_stream();
        int groups;
        int tail;
        int ending;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6)) send_char(t_byte'($urandom_range(0, 255)), 1'b0);
        end else begin
            groups = $urandom_range(0, 5);
            repeat (groups) begin
                if ($urandom_range(0, 7) == 0) send_noisy(CH_Z);
                else repeat (5) send_digit();
            end
            tail = $urandom_range(0, 4);
            repeat (tail) send_digit();
            ending = $urandom_range(0, 9);
            if (ending <= 5) begin
                send_char(CH_TILDE, 1'b0);
                send_char(CH_GT, 1'b0);
                repeat ($urandom_range(0, 2)) send_char(t_byte'($urandom_range(0, 255)), 1'b0);
            end else if (ending == 6) begin
                send_char(CH_TILDE, 1'b0);
                send_char(t_byte'($urandom_range(0, 255)), 1'b0);
            end
        end
        send_char(t_byte'($urandom_range(0, 255)), 1'b1);
        streams_sent++;
    endtask

    task automatic run_directed();
        send_char(CH_Z, 1'b0);
        repeat (5) send_char(CH_LAST, 1'b0);
        send_char(CH_FIRST, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(CH_DEL, 1'b0);
        send_char(CH_LAST, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(CH_TILDE, 1'b0);
        send_char(CH_GT, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h55, 1'b1);
        send_char(CH_FIRST, 1'b0);
        send_char(CH_Z, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'hAA, 1'b1);
        send_char(CH_TILDE, 1'b0);
        send_char(CH_SP, 1'b0);
        send_char(8'h00, 1'b1);
        streams_sent += 6;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (hold_long) begin
                hold_long     = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
                res_bus.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left    = $urandom_range(0, 3);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : char_source
        logic hold_done;
        hold_done             = 1'b0;
        items_sent            = 0;
        streams_sent          = 0;
        cycle_count           = 0;
        quiet                 = 1'b0;
        hold_long             = 1'b0;
        i_rst_n               = 1'b0;
        char_bus.valid        = 1'b0;
        char_bus.char_in      = '0;
        char_bus.end_of_input = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_long = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= QUIET_AT) quiet = 1'b1;
            send_stream();
        end
        char_bus.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);

        $display("Sent %0d characters in %0d streams, one long result hold-off included.",
                 items_sent, streams_sent);
        $display("Checked %0d data bytes, %0d flush and %0d error results.",
                 byte_count, flush_count, error_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
